FILE: hdl/tpe_pkg.sv
package tpe_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_STOPPED = 2'd1,
    ST_RUNNING = 2'd2
  } slot_st_t;

  localparam int MAX_RESULTS = 8;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  slot;
    logic [31:0] duration;
    logic        periodic;
    logic [31:0] user_word;
  } cmd_word_t;

endpackage

FILE: hdl/tpe_front.sv
module tpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpe_pkg::cmd_word_t  in_word,
  output logic                q_valid,
  output tpe_pkg::cmd_word_t  q_word,
  input  logic                q_pop
);
  import tpe_pkg::*;

  // two-entry queue between command intake and the slot engine
  cmd_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_word  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_word;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: hdl/tpe_back.sv
module tpe_back #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tpe_pkg::cmd_word_t  q_word,
  output logic                q_pop,
  output logic                out_valid,
  output logic                out_event_kind,
  output logic                out_status,
  output logic [2:0]          out_slot_id,
  output logic [31:0]         out_expiry_word,
  output logic                out_last
);
  import tpe_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {B_IDLE, B_DEC, B_WALK, B_SHIFT} bst_t;

  slot_st_t             st_r   [NUM_SLOTS];
  logic [TIME_BITS-1:0] dur_r  [NUM_SLOTS];
  logic [TIME_BITS-1:0] rem_r  [NUM_SLOTS];
  logic                 per_r  [NUM_SLOTS];
  logic [31:0]          word_r [NUM_SLOTS];
  logic [SW-1:0]        ord_r  [NUM_SLOTS];
  logic [CW-1:0]        act_r, used_r;

  bst_t          bs_r, bs_nxt;
  logic [CW-1:0] idx_r;      // walk index into active list
  logic [3:0]    n_r;        // expiries emitted this tick
  logic [SW-1:0] del_slot_r; // slot being removed during shift
  logic          del_resp_r; // shift on behalf of stop/free (respond after)
  logic          del_free_r;
  logic [CW-1:0] sh_r;       // shift position
  logic [2:0]    resp_id_r;

  logic          ov_r, ok_r, os_r, ol_r;
  logic [2:0]    oid_r;
  logic [31:0]   ow_r;

  cmd_t           cmd;
  logic           sv;
  logic [SW-1:0]  s;
  logic           found;
  logic [SW-1:0]  free_idx;
  logic [SW-1:0]  cur;
  logic           walk_more;
  logic [CW-1:0]  del_pos;
  logic [NUM_SLOTS-1:0] zero_v;
  logic           more_zero;

  assign cmd = cmd_t'(q_word.command);
  assign sv  = ({29'd0, q_word.slot} < NUM_SLOTS);
  assign s   = SW'(q_word.slot);
  assign cur = ord_r[idx_r[SW-1:0]];
  assign walk_more = (idx_r < act_r) && (n_r < 4'(MAX_RESULTS));

  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (st_r[i] == ST_UNUSED) begin
        found = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // list position of the addressed slot
  always_comb begin
    del_pos = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (ord_r[i] == s && CW'(i) < act_r) del_pos = CW'(i);
    end
  end

  // any running slot at zero further down the list, or reaching MAX_RESULTS, decides the last flag
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++)
      zero_v[i] = (st_r[i] == ST_RUNNING) && (rem_r[i] == '0);
    more_zero = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (CW'(j) > idx_r && CW'(j) < act_r && zero_v[ord_r[j]]) more_zero = 1'b1;
    end
  end

  assign q_pop = (bs_r == B_IDLE) && q_valid;

  always_comb begin
    bs_nxt = bs_r;
    unique case (bs_r)
      B_IDLE: begin
        if (q_valid && cmd == CMD_TICK) bs_nxt = B_DEC;
        else if (q_valid && sv && st_r[s] == ST_RUNNING &&
                 (cmd == CMD_STOP || cmd == CMD_FREE)) bs_nxt = B_SHIFT;
      end
      B_DEC:   bs_nxt = B_WALK;
      B_WALK: begin
        if (!walk_more) bs_nxt = B_IDLE;
        else if (st_r[cur] == ST_RUNNING && rem_r[cur] == '0 && !per_r[cur])
          bs_nxt = B_SHIFT;
      end
      B_SHIFT: begin
        if (sh_r + 1'b1 >= act_r) bs_nxt = del_resp_r ? B_IDLE : B_WALK;
      end
      default: bs_nxt = B_IDLE;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_event_kind  = ok_r;
  assign out_status      = os_r;
  assign out_slot_id     = oid_r;
  assign out_expiry_word = ow_r;
  assign out_last        = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= B_IDLE;
      ov_r <= 1'b0;
      act_r <= '0;
      used_r <= '0;
      idx_r <= '0;
      n_r <= '0;
      sh_r <= '0;
      del_resp_r <= 1'b0;
      del_free_r <= 1'b0;
      del_slot_r <= '0;
      resp_id_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i] <= ST_UNUSED; dur_r[i] <= '0; rem_r[i] <= '0;
        per_r[i] <= 1'b0; word_r[i] <= '0; ord_r[i] <= '0;
      end
    end else begin
      bs_r <= bs_nxt;
      ov_r <= 1'b0;
      ok_r <= 1'b0; os_r <= 1'b0; oid_r <= '0; ow_r <= '0; ol_r <= 1'b1;
      unique case (bs_r)
        B_IDLE: if (q_valid) begin
          os_r  <= 1'b1;
          oid_r <= q_word.slot;
          case (cmd)
            CMD_ALLOC: begin
              ov_r <= 1'b1; oid_r <= '0;
              if (used_r < CW'(NUM_SLOTS) && found) begin
                st_r[free_idx]   <= ST_STOPPED;
                dur_r[free_idx]  <= TIME_BITS'({32'd0, q_word.duration});
                word_r[free_idx] <= q_word.user_word;
                per_r[free_idx]  <= q_word.periodic;
                used_r <= used_r + 1'b1;
                oid_r <= 3'(free_idx);
                os_r <= 1'b0;
              end
            end
            CMD_START: begin
              ov_r <= 1'b1;
              if (sv && st_r[s] == ST_STOPPED) begin
                rem_r[s] <= dur_r[s];
                st_r[s] <= ST_RUNNING;
                ord_r[act_r[SW-1:0]] <= s;
                act_r <= act_r + 1'b1;
                os_r <= 1'b0;
              end
            end
            CMD_RESTART: begin
              ov_r <= 1'b1;
              if (sv && st_r[s] == ST_RUNNING) begin
                rem_r[s] <= dur_r[s];
                os_r <= 1'b0;
              end
            end
            CMD_STOP, CMD_FREE: begin
              if (sv && st_r[s] == ST_RUNNING) begin
                del_slot_r <= s; del_resp_r <= 1'b1;
                del_free_r <= (cmd == CMD_FREE);
                resp_id_r <= q_word.slot;
                st_r[s] <= ST_STOPPED;
                sh_r <= del_pos;
              end else begin
                ov_r <= 1'b1;
                if (cmd == CMD_FREE && sv && st_r[s] == ST_STOPPED) begin
                  st_r[s] <= ST_UNUSED; dur_r[s] <= '0; rem_r[s] <= '0;
                  word_r[s] <= '0; per_r[s] <= 1'b0;
                  used_r <= used_r - 1'b1;
                  os_r <= 1'b0;
                end
              end
            end
            CMD_TICK: begin
              idx_r <= '0; n_r <= '0;
            end
            default: begin
              ov_r <= 1'b1; oid_r <= '0;
            end
          endcase
        end
        B_DEC: begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (st_r[i] == ST_RUNNING && rem_r[i] != '0) rem_r[i] <= rem_r[i] - 1'b1;
        end
        B_WALK: begin
          if (walk_more) begin
            if (st_r[cur] == ST_RUNNING && rem_r[cur] == '0) begin
              ov_r <= 1'b1; ok_r <= 1'b1;
              oid_r <= 3'(cur); ow_r <= word_r[cur];
              n_r <= n_r + 1'b1;
              ol_r <= (n_r + 1'b1 == 4'(MAX_RESULTS)) || !more_zero;
              if (per_r[cur]) begin
                rem_r[cur] <= dur_r[cur];
                idx_r <= idx_r + 1'b1;
              end else begin
                st_r[cur] <= ST_STOPPED;
                del_resp_r <= 1'b0; del_free_r <= 1'b0;
                sh_r <= idx_r;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else if (n_r == '0) begin
            ov_r <= 1'b1;
          end
        end
        B_SHIFT: begin
          if (sh_r + 1'b1 < act_r) begin
            ord_r[sh_r[SW-1:0]] <= ord_r[sh_r[SW-1:0] + 1'b1];
            sh_r <= sh_r + 1'b1;
          end else begin
            act_r <= act_r - 1'b1;
            if (del_resp_r) begin
              ov_r <= 1'b1; oid_r <= resp_id_r;
              if (del_free_r) begin
                st_r[del_slot_r] <= ST_UNUSED; dur_r[del_slot_r] <= '0;
                rem_r[del_slot_r] <= '0; word_r[del_slot_r] <= '0;
                per_r[del_slot_r] <= 1'b0;
                used_r <= used_r - 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/timer_pool_with_expiry_events.sv
// A command is answered from an output register once the slot engine has taken it
// from the queue; stop/free of a running slot first shift the active-list entries behind it.
// Tick: a decrement pass, then a walk over the active entries, plus a shift pass
// from the removed entry to the list end for each one-shot expiry. The queue
// takes up to two commands while the engine is busy; busy is high when it is full.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall.
// Reset: synchronous on rst_n low; all slots unused, active list empty.
module timer_pool_with_expiry_events #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [2:0]  in_slot,
  input  logic [31:0] in_duration,
  input  logic        in_periodic,
  input  logic [31:0] in_user_word,
  output logic        out_valid,
  output logic        out_event_kind,
  output logic        out_status,
  output logic [2:0]  out_slot_id,
  output logic [31:0] out_expiry_word,
  output logic        out_last
);
  import tpe_pkg::*;

  cmd_word_t in_w, q_w;
  logic      q_valid, q_pop;

  assign in_w = '{command: in_command, slot: in_slot, duration: in_duration,
                  periodic: in_periodic, user_word: in_user_word};

  // front: command queue; back: slot engine
  tpe_front u_front (
    .clk, .rst_n, .start, .busy, .in_word(in_w),
    .q_valid, .q_word(q_w), .q_pop
  );

  tpe_back #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_word(q_w), .q_pop,
    .out_valid, .out_event_kind, .out_status, .out_slot_id,
    .out_expiry_word, .out_last
  );
endmodule

FILE: hdl/tpe_checker.sv
module tpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_event_kind,
  input logic        out_status,
  input logic [31:0] out_expiry_word
);
  a_exp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind |-> !out_status) else $error("expiry rejected");
  a_resp_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_kind |-> out_expiry_word == 32'd0) else $error("resp word");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !busy) else $error("busy after reset");
endmodule

bind timer_pool_with_expiry_events tpe_checker u_chk (
  .clk, .rst_n, .busy, .out_valid, .out_event_kind,
  .out_status, .out_expiry_word
);
